/* src/rnta_pkg.sv */
// ----------------------------------------------------------------------------
// rnta_pkg
// Shared types and constants for the ring neighbor token arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package rnta_pkg;

    localparam int DEF_MAX_REQUESTERS = 16;

    // fixed field widths
    localparam int REQ_W   = 4;
    localparam int TOKEN_W = 5;
    localparam int MEAL_W  = 16;
    localparam int NREQ_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reset values of the registers
    localparam logic [NREQ_W-1:0]  RST_NUM_REQUESTERS = NREQ_W'(16);
    localparam logic [TOKEN_W-1:0] RST_INITIAL_TOKENS = TOKEN_W'(5);
    localparam logic [MEAL_W-1:0]  RST_MEAL_LIMIT     = MEAL_W'(50);

    localparam logic [TOKEN_W-1:0] TOKEN_MAX = '1;
    localparam logic [MEAL_W-1:0]  MEAL_MAX  = '1;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_REQUESTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TOKENS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAL_LIMIT     = 2'd2;

    // operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

endpackage

`default_nettype wire

/* src/ring_neighbor_token_arbiter_core.sv */
// ----------------------------------------------------------------------------
// ring_neighbor_token_arbiter_core
// Token arbiter for requesters on a ring: grants a hungry requester when
// neither neighbor is eating and the shared pool holds a token.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    operation, requester
//  output    out_valid / out_ready  target, granted, bad_state, tokens_left,
//                                   finished, last
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  An input beat is held in an input register and evaluated into the result
//  register: a request checks the requester itself, a valid release checks
//  its left and then its right neighbor, all by the single grant evaluator.
//  A stalled result register holds the evaluation; input is taken again in
//  the cycle the last result of the held beat is produced.
//  Reset puts all requesters thinking and the pool at 5 tokens; config is
//  always ready and a write takes effect in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_neighbor_token_arbiter_core
    import rnta_pkg::*;
#(
    parameter int MAX_REQUESTERS = DEF_MAX_REQUESTERS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  operation,
    input  wire logic [REQ_W-1:0]      requester,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [REQ_W-1:0]           target,
    output logic                       granted,
    output logic                       bad_state,
    output logic [TOKEN_W-1:0]         tokens_left,
    output logic                       finished,
    output logic                       last,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IW  = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
    localparam int NW  = $clog2(MAX_REQUESTERS + 1);
    localparam int CW0 = (NW > NREQ_W) ? NW : NREQ_W;
    localparam int CW  = (CW0 > REQ_W) ? CW0 : REQ_W;

    // configuration
    logic [NREQ_W-1:0]         num_req_reg;
    logic [MEAL_W-1:0]         meal_limit_reg;

    // arbiter state
    logic [MAX_REQUESTERS-1:0] hungry_reg, hungry_next;
    logic [MAX_REQUESTERS-1:0] eat_reg, eat_next;
    logic [TOKEN_W-1:0]        pool_reg, pool_next;
    logic [MEAL_W-1:0]         meal_reg, meal_next;
    logic                      done_reg, done_next;

    // held input beat
    logic                      pend_reg;
    logic                      phase_reg;
    logic                      op_reg;
    logic [REQ_W-1:0]          x_reg;

    // result register
    logic                      out_valid_reg;
    logic [REQ_W-1:0]          target_reg;
    logic                      granted_reg;
    logic                      bad_reg;
    logic [TOKEN_W-1:0]        tokens_reg;
    logic                      finished_reg;
    logic                      last_reg;

    logic                      step_en;
    logic                      step_last;
    logic                      step_bad;
    logic                      step_grant;
    logic [CW-1:0]             n_cw;
    logic [CW-1:0]             x_cw;
    logic [CW-1:0]             t_cw;
    logic [CW-1:0]             tl_cw;
    logic [CW-1:0]             tr_cw;
    logic [IW-1:0]             x_idx;
    logic [IW-1:0]             t_idx;
    logic [IW-1:0]             tl_idx;
    logic [IW-1:0]             tr_idx;
    logic                      is_rel;

    function automatic logic [CW-1:0] ring_left(input logic [CW-1:0] i,
                                                input logic [CW-1:0] n);
        logic [CW-1:0] r;
        if (i == '0) r = n - CW'(1);
        else         r = i - CW'(1);
        return r;
    endfunction

    function automatic logic [CW-1:0] ring_right(input logic [CW-1:0] i,
                                                 input logic [CW-1:0] n);
        logic [CW-1:0] r;
        if (i == n - CW'(1)) r = '0;
        else                 r = i + CW'(1);
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign step_en   = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_reg || (step_en && step_last);

    // ring size clamped to the supported range
    always_comb
    begin
        n_cw = CW'(num_req_reg);
        if (n_cw < CW'(2))
            n_cw = CW'(2);
        else if (n_cw > CW'(MAX_REQUESTERS))
            n_cw = CW'(MAX_REQUESTERS);
    end

    assign x_cw   = CW'(x_reg);
    assign x_idx  = x_cw[IW-1:0];
    assign is_rel = (op_reg == OP_RELEASE);

    always_comb
    begin
        hungry_next = hungry_reg;
        eat_next    = eat_reg;
        pool_next   = pool_reg;
        meal_next   = meal_reg;
        done_next   = done_reg;
        t_cw        = x_cw;
        step_bad    = 1'b0;

        if (!phase_reg) begin
            if (x_cw >= n_cw)
                step_bad = 1'b1;
            else if (!is_rel)
                step_bad = hungry_reg[x_idx] || eat_reg[x_idx];
            else
                step_bad = !eat_reg[x_idx];

            if (!step_bad) begin
                if (!is_rel) begin
                    hungry_next[x_idx] = 1'b1;
                end
                else begin
                    eat_next[x_idx] = 1'b0;
                    if (pool_reg != TOKEN_MAX)
                        pool_next = pool_reg + TOKEN_W'(1);
                    if (meal_reg != MEAL_MAX)
                        meal_next = meal_reg + MEAL_W'(1);
                    if (meal_next >= meal_limit_reg)
                        done_next = 1'b1;
                    t_cw = ring_left(x_cw, n_cw);
                end
            end
        end
        else begin
            t_cw = ring_right(x_cw, n_cw);
        end

        // neighbor check on the updated state
        t_idx  = t_cw[IW-1:0];
        tl_cw  = ring_left(t_cw, n_cw);
        tr_cw  = ring_right(t_cw, n_cw);
        tl_idx = tl_cw[IW-1:0];
        tr_idx = tr_cw[IW-1:0];

        step_grant = !step_bad && !done_next && hungry_next[t_idx]
                     && !eat_next[tl_idx] && !eat_next[tr_idx]
                     && (pool_next != '0);

        if (step_grant) begin
            hungry_next[t_idx] = 1'b0;
            eat_next[t_idx]    = 1'b1;
            pool_next          = pool_next - TOKEN_W'(1);
        end

        step_last = step_bad || !is_rel || phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            num_req_reg    <= RST_NUM_REQUESTERS;
            meal_limit_reg <= RST_MEAL_LIMIT;
            hungry_reg     <= '0;
            eat_reg        <= '0;
            pool_reg       <= RST_INITIAL_TOKENS;
            meal_reg       <= '0;
            done_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            phase_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            if (step_en) begin
                hungry_reg <= hungry_next;
                eat_reg    <= eat_next;
                pool_reg   <= pool_next;
                meal_reg   <= meal_next;
                done_reg   <= done_next;
            end

            // a new beat is taken when none is held or the held one finishes this cycle
            if (in_valid && in_ready) begin
                pend_reg  <= 1'b1;
                phase_reg <= 1'b0;
            end
            else if (step_en) begin
                phase_reg <= !step_last;
                pend_reg  <= !step_last;
            end

            if (step_en)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // config writes are for the user to make only while idle; the block itself does not enforce it
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_NUM_REQUESTERS: num_req_reg    <= cfg_data[NREQ_W-1:0];
                    CFG_INITIAL_TOKENS: pool_reg       <= cfg_data[TOKEN_W-1:0];
                    CFG_MEAL_LIMIT:     meal_limit_reg <= cfg_data[MEAL_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            op_reg <= operation;
            x_reg  <= requester;
        end
        if (step_en) begin
            target_reg   <= t_cw[REQ_W-1:0];
            granted_reg  <= step_grant;
            bad_reg      <= step_bad;
            tokens_reg   <= pool_next;
            finished_reg <= done_next;
            last_reg     <= step_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign target      = target_reg;
    assign granted     = granted_reg;
    assign bad_state   = bad_reg;
    assign tokens_left = tokens_reg;
    assign finished    = finished_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire
